[src/bfa_pkg.sv]
// Package for the best-fit free-list allocator: field widths, status codes,
// slot record and ring control types. No dependencies.
package bfa_pkg;

  localparam int ADDR_W = 26;
  localparam int SIZE_W = 18;
  localparam int LEN_W  = 18;
  localparam int LIM_W  = 9;
  localparam int STAT_W = 3;
  localparam int HDR_BYTES = 8;

  localparam int DEF_PAGE_BYTES = 262144;
  localparam int DEF_FREE_SLOTS = 64;
  localparam int DEF_MAX_PAGES  = 256;
  localparam logic [LIM_W-1:0] PAGE_LIMIT_RST = 9'd256;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO_LEN  = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_PAGES  = 3'd3,
    ST_IGNORED   = 3'd4,
    ST_DBL_FREE  = 3'd5,
    ST_MERGED    = 3'd6
  } status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] hdr;
    logic [SIZE_W-1:0] size;
  } slot_t;

  // control of the slot ring: rotate, rewrite the head on its way around,
  // or load one cell directly while the ring sits at home position
  typedef struct packed {
    logic  shift;
    logic  head_en;
    slot_t head_slot;
    logic  load_en;
    slot_t load_slot;
  } ring_ctl_t;

endpackage

[src/bfa_ifs.sv]
// Channel interfaces of the allocator: request, response, config write.
// Depends on bfa_pkg.
interface bfa_req_if import bfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [LEN_W-1:0]  request_length;
  logic [ADDR_W-1:0] object_address;
  logic [SIZE_W-1:0] header_size;
  modport source (output valid, cmd, request_length, object_address, header_size,
                  input ready);
  modport sink   (input valid, cmd, request_length, object_address, header_size,
                  output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] granted_address;
  logic [SIZE_W-1:0] granted_size;
  modport source (output valid, status, granted_address, granted_size, input ready);
  modport sink   (input valid, status, granted_address, granted_size, output ready);
endinterface

interface bfa_cfg_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[src/bfa_slot_cell.sv]
// One free-slot cell: holds a slot record, takes its neighbor's on shift.
// Depends on bfa_pkg.
module bfa_slot_cell import bfa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  slot_t nb,
  input  logic  load,
  input  slot_t ld,
  output slot_t q
);
  logic              valid;
  logic [ADDR_W-1:0] hdr;
  logic [SIZE_W-1:0] size;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= ld.valid;
    end else if (shift) begin
      valid <= nb.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hdr  <= ld.hdr;
      size <= ld.size;
    end else if (shift) begin
      hdr  <= nb.hdr;
      size <= nb.size;
    end
  end

  assign q = '{valid: valid, hdr: hdr, size: size};
endmodule

[src/bfa_slot_ring.sv]
// Ring of slot cells; cell 0 is the head seen by the scan logic.
// Depends on bfa_pkg and bfa_slot_cell.
module bfa_slot_ring import bfa_pkg::*; #(
  parameter int FREE_SLOTS = DEF_FREE_SLOTS,
  localparam int IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  ring_ctl_t     ctl,
  input  logic [IW-1:0] load_idx,
  output slot_t         head
);
  slot_t cq [FREE_SLOTS];
  slot_t wrap;

  // head goes to the tail, rewritten if the scan asks for it
  assign wrap = ctl.head_en ? ctl.head_slot : cq[0];
  assign head = cq[0];

  for (genvar k = 0; k < FREE_SLOTS; k++) begin : g_cell
    slot_t nb;
    if (k == FREE_SLOTS - 1) begin : g_last
      assign nb = wrap;
    end else begin : g_mid
      assign nb = cq[k+1];
    end
    bfa_slot_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctl.shift),
      .nb    (nb),
      .load  (ctl.load_en && (load_idx == IW'(k))),
      .ld    (ctl.load_slot),
      .q     (cq[k])
    );
  end
endmodule

[src/best_fit_freelist_allocator_core.sv]
// Best-fit free-list allocator: top level with sequencer and bump pointer.
// Rejected requests skip the slot ring; other requests make one pass over it, and
// two when a page rolls over and its tail is freed.
// One request at a time; each pass rotates the slot ring once, one slot a cycle.
// Reset (sync, active high): slot valid bits, slot count and page base clear; page count goes to one.
module best_fit_freelist_allocator_core import bfa_pkg::*; #(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int FREE_SLOTS = DEF_FREE_SLOTS,
  parameter int MAX_PAGES  = DEF_MAX_PAGES
) (
  input logic clk,
  input logic rst,
  bfa_req_if.sink   req,
  bfa_rsp_if.source rsp,
  bfa_cfg_if.sink   cfg
);
  localparam int IW  = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int UW  = $clog2(FREE_SLOTS + 1);
  localparam int OW  = $clog2(PAGE_BYTES + 1);
  localparam int CW  = ((OW > LEN_W + 1) ? OW : LEN_W + 1) + 1;
  localparam int PW0 = $clog2(MAX_PAGES + 1);
  localparam int PW  = (PW0 > LIM_W) ? PW0 : LIM_W;

  typedef enum logic [2:0] {
    S_IDLE, S_ASCAN, S_AEND, S_FSCAN, S_FEND, S_NEWPG, S_GRANT, S_DONE
  } state_t;

  state_t state;

  // config
  logic [LIM_W-1:0] page_limit;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit <= PAGE_LIMIT_RST;
    end else if (cfg.valid) begin
      page_limit <= cfg.data;
    end
  end

  // allocator state
  logic [UW-1:0]     slots_in_use;
  logic [PW-1:0]     pages_opened;
  logic [ADDR_W-1:0] page_base;
  logic [OW-1:0]     next_offset;

  // request context
  logic [LEN_W:0]    len;       // rounded length
  logic [IW-1:0]     cnt;       // ring position of the head slot
  logic              best_found, adone;
  logic [IW-1:0]     best_idx;
  logic [SIZE_W-1:0] best_size;
  logic [ADDR_W-1:0] best_hdr;
  logic [ADDR_W-1:0] phdr;      // block to enter into the table
  logic [SIZE_W-1:0] psz;
  logic              pf_alloc;  // put_free issued for a page tail
  logic              pick_found, fdone;
  logic [IW-1:0]     pick_idx;
  status_t           fstat;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [SIZE_W-1:0] res_size;

  // output register
  logic              out_valid;
  status_t           out_status;
  logic [ADDR_W-1:0] out_addr;
  logic [SIZE_W-1:0] out_size;
  logic              out_load;
  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.granted_address = out_addr;
  assign rsp.granted_size    = out_size;

  // output register frees up when empty or being taken
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  assign req.ready = (state == S_IDLE);

  // ring
  ring_ctl_t     ctl;
  logic [IW-1:0] load_idx;
  slot_t         head;

  bfa_slot_ring #(.FREE_SLOTS(FREE_SLOTS)) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .load_idx (load_idx),
    .head     (head)
  );

  // request decode
  logic [LEN_W:0] len_round;
  assign len_round = ({1'b0, req.request_length} + (LEN_W+1)'(7)) & ~(LEN_W+1)'(7);

  logic last;
  assign last = (cnt == IW'(FREE_SLOTS - 1));

  logic full;
  assign full = (slots_in_use >= UW'(FREE_SLOTS));

  // put_free compares on the head slot
  logic [ADDR_W-1:0] after_a, head_end;
  logic              f_pick, f_m1, f_m2, f_rep;
  logic [SIZE_W-1:0] merged_size;
  assign after_a     = phdr + ADDR_W'(HDR_BYTES) + ADDR_W'(psz);
  assign head_end    = head.hdr + ADDR_W'(HDR_BYTES) + ADDR_W'(head.size);
  assign merged_size = head.size + psz + SIZE_W'(HDR_BYTES);
  assign f_pick = !fdone && !full && !pick_found && !head.valid;
  assign f_m1   = !fdone && head.valid && (head.hdr == after_a);
  assign f_m2   = !fdone && head.valid && !f_m1 && (head_end == phdr);
  assign f_rep  = !fdone && head.valid && !f_m1 && !f_m2 && full && (head.size < psz);

  // best-fit compare on the head slot
  logic a_take;
  assign a_take = !adone && head.valid && ({1'b0, head.size} >= len) &&
                  (!best_found || head.size <= best_size);

  // bump-pointer tests
  logic [CW-1:0] lim_bytes;
  logic          over, tail_ok, no_pages;
  logic [PW-1:0] lim;
  assign lim_bytes = CW'(next_offset) + CW'(len) + CW'(HDR_BYTES);
  assign over      = lim_bytes > CW'(PAGE_BYTES);
  assign tail_ok   = (CW'(next_offset) + CW'(2 * HDR_BYTES)) <= CW'(PAGE_BYTES);
  assign lim       = (PW'(page_limit) < PW'(MAX_PAGES)) ? PW'(page_limit) : PW'(MAX_PAGES);
  assign no_pages  = pages_opened >= lim;

  logic [CW-1:0] tail_sz;
  assign tail_sz = CW'(PAGE_BYTES) - CW'(next_offset) - CW'(HDR_BYTES);

  always_comb begin
    ctl      = '0;
    load_idx = cnt;
    case (state)
      S_ASCAN: ctl.shift = 1'b1;
      S_FSCAN: begin
        ctl.shift = 1'b1;
        if (f_m1) begin
          ctl.head_en   = 1'b1;
          ctl.head_slot = '{valid: 1'b1, hdr: phdr, size: merged_size};
        end else if (f_m2) begin
          ctl.head_en   = 1'b1;
          ctl.head_slot = '{valid: 1'b1, hdr: head.hdr, size: merged_size};
        end else if (f_rep) begin
          ctl.head_en   = 1'b1;
          ctl.head_slot = '{valid: 1'b1, hdr: phdr, size: psz};
        end
      end
      S_AEND: begin
        ctl.load_en   = best_found;
        ctl.load_slot = '{valid: 1'b0, hdr: best_hdr, size: best_size};
        load_idx      = best_idx;
      end
      S_FEND: begin
        ctl.load_en   = !fdone && pick_found;
        ctl.load_slot = '{valid: 1'b1, hdr: phdr, size: psz};
        load_idx      = pick_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      slots_in_use <= '0;
      pages_opened <= PW'(1);
      page_base    <= '0;
      next_offset  <= OW'(HDR_BYTES);
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cnt        <= '0;
          best_found <= 1'b0;
          adone      <= 1'b0;
          pick_found <= 1'b0;
          fdone      <= 1'b0;
          fstat      <= ST_OK;
          pf_alloc   <= 1'b0;
          res_addr   <= '0;
          res_size   <= '0;
          len        <= len_round;
          phdr       <= req.object_address - ADDR_W'(HDR_BYTES);
          psz        <= req.header_size;
          if (req.valid) begin
            if (req.cmd == CMD_ALLOC) begin
              if (req.request_length == '0) begin
                res_status <= ST_ZERO_LEN;
                state      <= S_DONE;
              end else if (CW'(len_round) > CW'(PAGE_BYTES - 2 * HDR_BYTES)) begin
                res_status <= ST_TOO_LARGE;
                state      <= S_DONE;
              end else begin
                state <= S_ASCAN;
              end
            end else begin
              if (req.object_address == '0) begin
                res_status <= ST_IGNORED;
                state      <= S_DONE;
              end else if (req.header_size == '0) begin
                res_status <= ST_DBL_FREE;
                state      <= S_DONE;
              end else begin
                state <= S_FSCAN;
              end
            end
          end
        end
        S_ASCAN: begin
          if (a_take) begin
            best_found <= 1'b1;
            best_idx   <= cnt;
            best_size  <= head.size;
            best_hdr   <= head.hdr;
            if ({1'b0, head.size} == len) adone <= 1'b1;
          end
          cnt <= cnt + IW'(1);
          if (last) begin
            cnt   <= '0;
            state <= S_AEND;
          end
        end
        S_AEND: begin
          if (best_found) begin
            slots_in_use <= slots_in_use - UW'(1);
            res_status   <= ST_OK;
            res_addr     <= best_hdr + ADDR_W'(HDR_BYTES);
            res_size     <= best_size;
            state        <= S_DONE;
          end else if (!over) begin
            state <= S_GRANT;
          end else if (no_pages) begin
            res_status <= ST_NO_PAGES;
            state      <= S_DONE;
          end else if (tail_ok) begin
            phdr     <= page_base + ADDR_W'(next_offset);
            psz      <= tail_sz[SIZE_W-1:0];
            pf_alloc <= 1'b1;
            state    <= S_FSCAN;
          end else begin
            state <= S_NEWPG;
          end
        end
        S_FSCAN: begin
          if (f_pick) begin
            pick_found <= 1'b1;
            pick_idx   <= cnt;
          end
          if (f_m1 || f_m2) begin
            fdone <= 1'b1;
            fstat <= ST_MERGED;
          end else if (f_rep) begin
            fdone <= 1'b1;
            fstat <= ST_OK;
          end
          cnt <= cnt + IW'(1);
          if (last) begin
            cnt   <= '0;
            state <= S_FEND;
          end
        end
        S_FEND: begin
          if (fdone) begin
            res_status <= fstat;
          end else if (pick_found) begin
            slots_in_use <= slots_in_use + UW'(1);
            res_status   <= ST_OK;
          end else begin
            res_status <= ST_IGNORED;
          end
          state <= pf_alloc ? S_NEWPG : S_DONE;
        end
        S_NEWPG: begin
          page_base    <= page_base + ADDR_W'(PAGE_BYTES);
          pages_opened <= pages_opened + PW'(1);
          next_offset  <= OW'(HDR_BYTES);
          state        <= S_GRANT;
        end
        S_GRANT: begin
          res_status  <= ST_OK;
          res_addr    <= page_base + ADDR_W'(next_offset) + ADDR_W'(HDR_BYTES);
          res_size    <= len[SIZE_W-1:0];
          next_offset <= next_offset + OW'(len) + OW'(HDR_BYTES);
          state       <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_status <= res_status;
            out_addr   <= res_addr;
            out_size   <= res_size;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_in_use <= UW'(FREE_SLOTS))
    else $error("slot count above table size");

  a_pages_nonzero: assert property (@(posedge clk) disable iff (rst)
    pages_opened != '0)
    else $error("no page open");

  a_ring_home: assert property (@(posedge clk) disable iff (rst)
    (state == S_AEND || state == S_FEND) |-> cnt == '0)
    else $error("ring not at home position after a pass");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state != S_IDLE)
    else $error("accepted request produced no work");
endmodule

[tb/testbench.sv]
// Self-checking bench for best_fit_freelist_allocator_core: a scoreboard class
// predicts each response from accepted requests. Depends on bfa_pkg, bfa_ifs and the core.
module testbench;
  import bfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned PAGE = DEF_PAGE_BYTES;
  localparam int NSLOT = DEF_FREE_SLOTS;
  localparam longint unsigned AMASK = 64'h3FF_FFFF;
  localparam longint unsigned SMASK = 64'h3_FFFF;
  localparam int SETTLE = 2 * DEF_FREE_SLOTS + 20;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } grant_t;

  // Allocator predictor plus the queue of responses still owed by the block.
  class alloc_scoreboard;
    logic [ADDR_W-1:0] hdr_at[NSLOT];
    logic [SIZE_W-1:0] size_at[NSLOT];
    bit                used[NSLOT];
    int                used_count = 0;
    int                cur_page = 0;
    int                pages_open = 1;
    int                next_off = HDR_BYTES;
    int                page_limit = PAGE_LIMIT_RST;
    grant_t            owed[$];
    int                errors = 0;

    function status_t free_block(longint unsigned hdr, longint unsigned sz);
      longint unsigned after, blk_end;
      bit full;
      int pick;
      after = (hdr + HDR_BYTES + sz) & AMASK;
      full  = used_count >= NSLOT;
      pick  = -1;
      hdr   = hdr & AMASK;
      for (int i = 0; i < NSLOT; i++) begin
        if (!full && pick < 0 && !used[i]) begin
          pick = i;
        end else if (used[i]) begin
          blk_end = (hdr_at[i] + HDR_BYTES + size_at[i]) & AMASK;
          if (hdr_at[i] == after) begin
            // block sits right in front of this slot: slot grows backward
            hdr_at[i]  = ADDR_W'(hdr);
            size_at[i] = SIZE_W'((size_at[i] + sz + HDR_BYTES) & SMASK);
            return ST_MERGED;
          end else if (blk_end == hdr) begin
            size_at[i] = SIZE_W'((size_at[i] + sz + HDR_BYTES) & SMASK);
            return ST_MERGED;
          end else if (full && size_at[i] < sz) begin
            pick = i;
            break;
          end
        end
      end
      if (pick < 0) return ST_IGNORED;
      if (!used[pick]) begin
        used[pick] = 1;
        used_count++;
      end
      hdr_at[pick]  = ADDR_W'(hdr);
      size_at[pick] = SIZE_W'(sz & SMASK);
      return ST_OK;
    endfunction

    function grant_t note_request(logic cmd, logic [LEN_W-1:0] len_in,
                                  logic [ADDR_W-1:0] obj, logic [SIZE_W-1:0] hsz);
      grant_t g;
      longint unsigned len, hdr;
      int best, lim;
      g.status = ST_OK;
      g.addr = '0;
      g.size = '0;
      if (cmd == CMD_ALLOC) begin
        len = 64'(len_in);
        if (len == 0) begin
          g.status = ST_ZERO_LEN;
        end else begin
          len = (len + 7) & ~64'd7;
          if (len > PAGE - 2 * HDR_BYTES) begin
            g.status = ST_TOO_LARGE;
          end else begin
            best = -1;
            for (int i = 0; i < NSLOT; i++) begin
              if (!used[i] || size_at[i] < len) continue;
              if (best < 0 || size_at[i] <= size_at[best]) begin
                best = i;
                if (size_at[i] == len) break;   // exact fit ends the search
              end
            end
            if (best >= 0) begin
              g.addr = ADDR_W'((hdr_at[best] + HDR_BYTES) & AMASK);
              g.size = size_at[best];
              used[best] = 0;
              used_count--;
            end else begin
              lim = page_limit < DEF_MAX_PAGES ? page_limit : DEF_MAX_PAGES;
              if (next_off + len + HDR_BYTES > PAGE) begin
                if (pages_open >= lim) begin
                  g.status = ST_NO_PAGES;
                end else begin
                  // retire the tail of the page into the table if usable
                  if (next_off + 2 * HDR_BYTES <= PAGE)
                    void'(free_block(cur_page * PAGE + next_off,
                                     PAGE - next_off - HDR_BYTES));
                  cur_page++;
                  pages_open++;
                  next_off = HDR_BYTES;
                end
              end
              if (g.status == ST_OK) begin
                hdr = cur_page * PAGE + next_off;
                g.addr = ADDR_W'((hdr + HDR_BYTES) & AMASK);
                g.size = SIZE_W'(len);
                next_off += int'(len) + HDR_BYTES;
              end
            end
          end
        end
      end else begin
        if (obj == 0) g.status = ST_IGNORED;
        else if (hsz == 0) g.status = ST_DBL_FREE;
        else g.status = free_block((obj - HDR_BYTES) & AMASK, hsz);
      end
      owed.push_back(g);
      return g;
    endfunction

    function void check_response(logic [STAT_W-1:0] st, logic [ADDR_W-1:0] a,
                                 logic [SIZE_W-1:0] s);
      grant_t g;
      if (owed.size() == 0) begin
        $error("response with no request pending: status %0d", st);
        errors++;
        return;
      end
      g = owed.pop_front();
      if (st !== g.status) begin
        $error("status: expected %0d, got %0d", g.status, st);
        errors++;
      end
      if (a !== g.addr) begin
        $error("granted_address: expected %h, got %h", g.addr, a);
        errors++;
      end
      if (s !== g.size) begin
        $error("granted_size: expected %h, got %h", g.size, s);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  bfa_req_if req();
  bfa_rsp_if rsp();
  bfa_cfg_if cfg();

  best_fit_freelist_allocator_core dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  alloc_scoreboard sb = new();
  bit calm = 0;   // no idling while set

  // live blocks the bench may free later
  logic [ADDR_W-1:0] live_addr[$];
  logic [SIZE_W-1:0] live_size[$];

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pause_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 96) return $urandom_range(3, 12);
    return $urandom_range(40, 200);
  endfunction

  initial begin
    req.valid = 0;
    req.cmd = CMD_ALLOC;
    req.request_length = '0;
    req.object_address = '0;
    req.header_size = '0;
    cfg.valid = 0;
    cfg.data = '0;
    rsp.ready = 0;
  end

  // Receiver stalls: random low stretches, random high stretches.
  initial begin
    @(negedge clk);
    forever begin
      repeat (pause_len()) begin
        rsp.ready <= 0;
        @(negedge clk);
      end
      repeat ($urandom_range(1, 20)) begin
        rsp.ready <= 1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_response(rsp.status, rsp.granted_address, rsp.granted_size);
  end

  task automatic send_request(logic cmd, logic [LEN_W-1:0] len,
                              logic [ADDR_W-1:0] obj, logic [SIZE_W-1:0] hsz);
    int n;
    grant_t g;
    n = pause_len();
    if (n > 0) begin
      @(negedge clk);
      req.valid <= 0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid <= 1;
    req.cmd <= cmd;
    req.request_length <= len;
    req.object_address <= obj;
    req.header_size <= hsz;
    do @(posedge clk); while (!req.ready);
    g = sb.note_request(cmd, len, obj, hsz);
    if (cmd == CMD_ALLOC && g.status == ST_OK) begin
      live_addr.push_back(g.addr);
      live_size.push_back(g.size);
    end
  endtask

  task automatic alloc(logic [LEN_W-1:0] len);
    send_request(CMD_ALLOC, len, ADDR_W'($urandom), SIZE_W'($urandom));
  endtask

  // Free a live block with its own size word, or with a zero size word (a double free) and keep it live.
  task automatic free_live(bit keep);
    int k;
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] s;
    if (live_addr.size() == 0) begin
      alloc(LEN_W'($urandom_range(1, 300)));
      return;
    end
    k = $urandom_range(0, live_addr.size() - 1);
    a = live_addr[k];
    s = live_size[k];
    if (!keep) begin
      live_addr.delete(k);
      live_size.delete(k);
    end
    send_request(CMD_FREE, LEN_W'($urandom), a, keep ? '0 : s);
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] v);
    drain();
    @(negedge clk);
    cfg.valid <= 1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    sb.page_limit = int'(v);
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task automatic random_phase(int items);
    int r;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) alloc(LEN_W'($urandom_range(1, 600)));
      else if (r < 50) alloc(LEN_W'($urandom_range(600, 262128)));
      else if (r < 85) free_live(0);
      else if (r < 88) free_live(1);
      else if (r < 91) alloc(LEN_W'($urandom));
      else if (r < 93) alloc('0);
      else if (r < 95) send_request(CMD_FREE, LEN_W'($urandom), '0, SIZE_W'($urandom));
      else send_request(CMD_FREE, LEN_W'($urandom), ADDR_W'($urandom),
                        SIZE_W'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, rollover, rejects, exact fit, merges, double free
    alloc('0);
    alloc(18'd1);
    alloc(18'd9);
    alloc(18'd262128);          // forces a new page and frees the tail
    alloc(18'd262129);          // rounds past the limit
    alloc(18'h3FFFF);
    alloc(18'd24);
    send_request(CMD_FREE, '1, '0, '1);
    free_live(1);               // double free
    free_live(0);
    free_live(0);
    free_live(0);
    alloc(18'd16);
    alloc(18'd8);
    alloc(18'd200);
    send_request(CMD_FREE, '0, '1, '1);
    send_request(CMD_FREE, '0, 26'd8, 18'd1);

    // single page allowed: rollover reports out of pages
    write_limit(9'd1);
    alloc(18'd262000);
    alloc(18'd262000);
    random_phase(250);

    write_limit(9'd0);
    random_phase(250);

    write_limit(9'h1FF);
    calm = 1;
    random_phase(250);
    calm = 0;

    write_limit(9'd3);
    random_phase(250);

    write_limit(PAGE_LIMIT_RST);
    random_phase(300);

    write_limit(LIM_W'($urandom_range(1, 511)));
    random_phase(300);

    drain();
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
